/* hdl/tsc_pkg.sv */
// Shared types, constants and codes for the touch sample conditioner.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    // Conversions per axis group; a scan is X, Y, X, Y groups
    localparam int SAMPLES_PER_AXIS = 5;
    localparam int SAMPLE_W         = 12;
    localparam int POS_W            = $clog2(SAMPLES_PER_AXIS);
    localparam int SUM_W            = SAMPLE_W + $clog2(SAMPLES_PER_AXIS);

    // Trimmed mean divides by (N - 2): reciprocal multiply, exact for SUM_W <= 16
    localparam int TRIM_DIV   = SAMPLES_PER_AXIS - 2;
    localparam int MEAN_SHIFT = 24;
    localparam int RECIP_W    = MEAN_SHIFT + 1;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((1 << MEAN_SHIFT) + TRIM_DIV - 1) / TRIM_DIV);
    localparam int MEAN_PROD_W = SUM_W + RECIP_W;

    // Calibration arithmetic
    localparam int WIN_W      = 12;
    localparam int GAIN_W     = 20;
    localparam int OFFSET_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int MAP_PROD_W = GAIN_W + SAMPLE_W + 1;
    localparam int MAP_SUM_W  = MAP_PROD_W + 1;

    localparam logic [WIN_W-1:0] AGREE_RESET = WIN_W'(50);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGREE_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd5;

    // Group positions within a scan
    localparam logic [1:0] GRP_X1 = 2'd0;
    localparam logic [1:0] GRP_Y1 = 2'd1;
    localparam logic [1:0] GRP_X2 = 2'd2;
    localparam logic [1:0] GRP_Y2 = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_PEN_UP = 2'd1,
        KIND_ACK    = 2'd2
    } kind_t;

    typedef enum logic {
        OP_GROUP,
        OP_REPORT
    } op_t;

    // One queued job: a finished group or a flags-only report
    typedef struct packed {
        op_t              op;
        logic [1:0]       grp;
        logic             held;
        logic             pending;
        logic [SUM_W-1:0] tsum;
    } entry_t;

    typedef struct packed {
        logic                       raw_mode;
        logic [WIN_W-1:0]           agree_window;
        logic signed [GAIN_W-1:0]   x_gain;
        logic signed [OFFSET_W-1:0] x_offset;
        logic signed [GAIN_W-1:0]   y_gain;
        logic signed [OFFSET_W-1:0] y_offset;
    } cfg_t;

    typedef struct packed {
        logic                pen_held;
        logic                press_pending;
        logic                reading_valid;
        logic [SAMPLE_W-1:0] raw_x;
        logic [SAMPLE_W-1:0] raw_y;
        logic [SAMPLE_W-1:0] screen_x;
        logic [SAMPLE_W-1:0] screen_y;
    } result_t;

endpackage

`default_nettype wire

/* hdl/tsc_front.sv */
// Front end: accepts transactions, tracks pen flags, accumulates groups.
`timescale 1ns / 1ps
`default_nettype none

module tsc_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [1:0]              kind,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                    q_full,
    output logic                         push,
    output tsc_pkg::entry_t              push_entry
);
    import tsc_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES_PER_AXIS - 1);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [1:0]          grp_reg, grp_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic                held_reg, held_next;
    logic                pend_reg, pend_next;

    logic                accept;
    logic [SUM_W-1:0]    sum_acc;
    logic [SAMPLE_W-1:0] min_acc;
    logic [SAMPLE_W-1:0] max_acc;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Running group statistics including the current conversion
    assign sum_acc = sum_reg + SUM_W'(sample);
    assign min_acc = (sample < min_reg) ? sample : min_reg;
    assign max_acc = (sample > max_reg) ? sample : max_reg;

    // Classify the transaction and update scan state
    always_comb begin
        pos_next  = pos_reg;
        grp_next  = grp_reg;
        sum_next  = sum_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        held_next = held_reg;
        pend_next = pend_reg;
        push      = 1'b0;
        push_entry.op = OP_REPORT;
        push_entry.grp = grp_reg;
        push_entry.tsum = SUM_W'(sum_acc - SUM_W'(min_acc) - SUM_W'(max_acc));
        if (accept) begin
            case (kind_t'(kind))
                KIND_SAMPLE: begin
                    if (!held_reg) begin
                        held_next = 1'b1;
                        pend_next = 1'b1;
                    end
                    if (pos_reg == POS_LAST) begin
                        push          = 1'b1;
                        push_entry.op = OP_GROUP;
                        pos_next      = '0;
                        grp_next      = grp_reg + 2'd1;
                        sum_next      = '0;
                        min_next      = '1;
                        max_next      = '0;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                        sum_next = sum_acc;
                        min_next = min_acc;
                        max_next = max_acc;
                    end
                end
                KIND_PEN_UP: begin
                    held_next = 1'b0;
                    pos_next  = '0;
                    grp_next  = GRP_X1;
                    sum_next  = '0;
                    min_next  = '1;
                    max_next  = '0;
                    push      = 1'b1;
                end
                KIND_ACK: begin
                    pend_next = 1'b0;
                    push      = 1'b1;
                end
                default: begin
                end
            endcase
        end
        push_entry.held    = held_next;
        push_entry.pending = pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            grp_reg  <= GRP_X1;
            sum_reg  <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
            held_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            grp_reg  <= grp_next;
            sum_reg  <= sum_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
            held_reg <= held_next;
            pend_reg <= pend_next;
        end
    end

    // Position never runs past the last conversion of a group
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("group position out of range");

endmodule

`default_nettype wire

/* hdl/tsc_queue.sv */
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module tsc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire tsc_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output tsc_pkg::entry_t      head
);
    import tsc_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Storage carries no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue push while full");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0]))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* hdl/tsc_back.sv */
// Back end: trimmed mean, round agreement, calibration mapping, result register.
`timescale 1ns / 1ps
`default_nettype none

module tsc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tsc_pkg::cfg_t   cfg,
    input  wire logic            q_empty,
    input  wire tsc_pkg::entry_t head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output tsc_pkg::result_t     result
);
    import tsc_pkg::*;

    // Clamp a Q.16 mapped value to the 0..4095 screen range
    function automatic logic [SAMPLE_W-1:0] clamp_axis(input logic [MAP_SUM_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        if (v[MAP_SUM_W-1]) begin
            r = '0;
        end else if (|v[MAP_SUM_W-2:FRAC_W+SAMPLE_W]) begin
            r = '1;
        end else begin
            r = v[FRAC_W +: SAMPLE_W];
        end
        return r;
    endfunction

    logic adv;

    // Stage 1: job plus reciprocal product
    logic                   s1_valid_reg;
    op_t                    s1_op_reg;
    logic [1:0]             s1_grp_reg;
    logic                   s1_held_reg, s1_pend_reg;
    logic [MEAN_PROD_W-1:0] s1_prod_reg;

    // Stage 2: agreement result and raw averages
    logic                s2_valid_reg, s2_held_reg, s2_pend_reg, s2_rvalid_reg;
    logic [SAMPLE_W-1:0] s2_rawx_reg, s2_rawy_reg;

    // Stage 3: calibration products
    logic                        s3_valid_reg, s3_held_reg, s3_pend_reg, s3_rvalid_reg;
    logic [SAMPLE_W-1:0]         s3_rawx_reg, s3_rawy_reg;
    logic signed [MAP_PROD_W-1:0] s3_px_reg, s3_py_reg;

    // Round means and held coordinates
    logic [SAMPLE_W-1:0] fx_reg, fy_reg, sx_reg;
    logic [SAMPLE_W-1:0] hraw_x_reg, hraw_y_reg, hscr_x_reg, hscr_y_reg;
    logic [SAMPLE_W-1:0] hraw_x_next, hraw_y_next, hscr_x_next, hscr_y_next;

    logic    out_valid_reg;
    result_t out_reg;

    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] dx, dy;
    logic                agree_ok, scan_done;
    logic [SAMPLE_W:0]   sum_x, sum_y;
    logic [MAP_SUM_W-1:0] vx, vy;
    logic [SAMPLE_W-1:0] scr_x, scr_y;

    // The whole back end moves unless a result is waiting downstream
    assign adv      = !(out_valid_reg && !m_tready);
    assign pop      = adv && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    // Stage 2 arithmetic
    assign mean      = s1_prod_reg[MEAN_SHIFT +: SAMPLE_W];
    assign dx        = (fx_reg >= sx_reg) ? (fx_reg - sx_reg) : (sx_reg - fx_reg);
    assign dy        = (fy_reg >= mean) ? (fy_reg - mean) : (mean - fy_reg);
    assign agree_ok  = (dx < cfg.agree_window) && (dy < cfg.agree_window);
    assign sum_x     = {1'b0, fx_reg} + {1'b0, sx_reg};
    assign sum_y     = {1'b0, fy_reg} + {1'b0, mean};
    assign scan_done = (s1_op_reg == OP_GROUP) && (s1_grp_reg == GRP_Y2);

    // Stage 4 arithmetic: add offset and clamp
    assign vx = {s3_px_reg[MAP_PROD_W-1], s3_px_reg}
              + {{(MAP_SUM_W-OFFSET_W-FRAC_W){cfg.x_offset[OFFSET_W-1]}},
                 cfg.x_offset, {FRAC_W{1'b0}}};
    assign vy = {s3_py_reg[MAP_PROD_W-1], s3_py_reg}
              + {{(MAP_SUM_W-OFFSET_W-FRAC_W){cfg.y_offset[OFFSET_W-1]}},
                 cfg.y_offset, {FRAC_W{1'b0}}};
    assign scr_x = clamp_axis(vx);
    assign scr_y = clamp_axis(vy);

    // Held coordinates after the job in the last stage
    always_comb begin
        hraw_x_next = hraw_x_reg;
        hraw_y_next = hraw_y_reg;
        hscr_x_next = hscr_x_reg;
        hscr_y_next = hscr_y_reg;
        if (s3_valid_reg && s3_rvalid_reg) begin
            hraw_x_next = s3_rawx_reg;
            hraw_y_next = s3_rawy_reg;
            if (!cfg.raw_mode) begin
                hscr_x_next = scr_x;
                hscr_y_next = scr_y;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg   <= head.op;
            s1_grp_reg  <= head.grp;
            s1_held_reg <= head.held;
            s1_pend_reg <= head.pending;
            s1_prod_reg <= MEAN_PROD_W'(head.tsum * MEAN_RECIP);

            s2_held_reg   <= s1_held_reg;
            s2_pend_reg   <= s1_pend_reg;
            s2_rvalid_reg <= scan_done && agree_ok;
            s2_rawx_reg   <= sum_x[SAMPLE_W:1];
            s2_rawy_reg   <= sum_y[SAMPLE_W:1];

            s3_held_reg   <= s2_held_reg;
            s3_pend_reg   <= s2_pend_reg;
            s3_rvalid_reg <= s2_rvalid_reg;
            s3_rawx_reg   <= s2_rawx_reg;
            s3_rawy_reg   <= s2_rawy_reg;
            s3_px_reg     <= MAP_PROD_W'(cfg.x_gain)
                           * MAP_PROD_W'($signed({1'b0, s2_rawx_reg}));
            s3_py_reg     <= MAP_PROD_W'(cfg.y_gain)
                           * MAP_PROD_W'($signed({1'b0, s2_rawy_reg}));

            out_reg.pen_held      <= s3_held_reg;
            out_reg.press_pending <= s3_pend_reg;
            out_reg.reading_valid <= s3_rvalid_reg;
            out_reg.raw_x         <= hraw_x_next;
            out_reg.raw_y         <= hraw_y_next;
            out_reg.screen_x      <= hscr_x_next;
            out_reg.screen_y      <= hscr_y_next;
        end
    end

    // Control and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            sx_reg        <= '0;
            hraw_x_reg    <= '0;
            hraw_y_reg    <= '0;
            hscr_x_reg    <= '0;
            hscr_y_reg    <= '0;
        end else if (adv) begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg && ((s1_op_reg == OP_REPORT) || scan_done);
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg && (s1_op_reg == OP_GROUP)) begin
                case (s1_grp_reg)
                    GRP_X1:  fx_reg <= mean;
                    GRP_Y1:  fy_reg <= mean;
                    GRP_X2:  sx_reg <= mean;
                    default: begin
                    end
                endcase
            end
            hraw_x_reg <= hraw_x_next;
            hraw_y_reg <= hraw_y_next;
            hscr_x_reg <= hscr_x_next;
            hscr_y_reg <= hscr_y_next;
        end
    end

    // A completed scan only comes from pen-down conversions
    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.reading_valid) |-> out_reg.pen_held)
        else $error("valid reading without pen held");

endmodule

`default_nettype wire

/* hdl/touch_sample_conditioner.sv */
// Path: a result on m_tvalid passes from its input transaction through the registers
// of the queue, trimmed-mean multiply, agreement, calibration multiply and output register.
// Throughput: one input transaction per cycle while m_tready stays high; the
// four-entry job queue and the output register set how far a stall is absorbed.
// Reset: synchronous, active low; clears scan state, held coordinates, pen flags
// and configuration (agree window 50). No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_conditioner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] sample
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [0] pen_held, [1] press_pending,
                                        // [2] reading_valid, [14:3] raw_x,
                                        // [26:15] raw_y, [38:27] screen_x,
                                        // [50:39] screen_y
    // Configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import tsc_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full, q_empty, push, pop;
    entry_t  push_entry, head;
    result_t result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.raw_mode     <= 1'b0;
            cfg_reg.agree_window <= AGREE_RESET;
            cfg_reg.x_gain       <= '0;
            cfg_reg.x_offset     <= '0;
            cfg_reg.y_gain       <= '0;
            cfg_reg.y_offset     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RAW_MODE:     cfg_reg.raw_mode     <= cfg_wdata[0];
                REG_AGREE_WINDOW: cfg_reg.agree_window <= cfg_wdata[WIN_W-1:0];
                REG_X_GAIN:       cfg_reg.x_gain       <= cfg_wdata[GAIN_W-1:0];
                REG_X_OFFSET:     cfg_reg.x_offset     <= cfg_wdata[OFFSET_W-1:0];
                REG_Y_GAIN:       cfg_reg.y_gain       <= cfg_wdata[GAIN_W-1:0];
                REG_Y_OFFSET:     cfg_reg.y_offset     <= cfg_wdata[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tsc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .kind       (s_tuser),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    tsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    tsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    // Pack result fields, lowest first
    assign m_tdata = {5'b0, result.screen_y, result.screen_x, result.raw_y, result.raw_x,
                      result.reading_valid, result.press_pending, result.pen_held};

endmodule

`default_nettype wire
